/* rtl/core/sghs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sghs_pkg;

	localparam int MAP_SIDE   = 256;
	localparam int MAX_BEAMS  = 4096;
	localparam int CELL_W     = $clog2(MAP_SIDE);
	localparam int LIM_W      = CELL_W + 1;
	localparam int ADDR_W     = 2 * CELL_W;
	localparam int GRID_CELLS = MAP_SIDE * MAP_SIDE;

	localparam int CNT_W      = 13;
	localparam int SCORE_W    = 16;
	localparam int HIT_WEIGHT = 10;

	localparam int ANG_W        = 16;
	localparam int Z_W          = 17;
	localparam int CORDIC_W     = 27;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_W       = 14;
	localparam int GAIN_W       = 18;
	localparam int INV_GAIN     = 39797;
	localparam int PROD_W       = CORDIC_W + GAIN_W;
	localparam int FRAC_SHIFT   = 16;
	localparam int DELTA_W      = PROD_W - FRAC_SHIFT;

	localparam int POSE_W     = 24;
	localparam int POSE_SH_W  = POSE_W + 8;
	localparam int POS_W      = 34;
	localparam int DIVIDEND_W = POS_W - 1;
	localparam int DIVISOR_W  = 24;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSE_X,
		REG_POSE_Y,
		REG_HEADING,
		REG_ANGLE_STEP,
		REG_CELL_SIZE,
		REG_MAP_WIDTH,
		REG_MAP_HEIGHT,
		REG_THRESHOLD
	} cfg_reg_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_BEAM  = 1'b1;

	// Arctangent of 2^-i in binary angle units (65536 per turn).
	function automatic logic [ATAN_W-1:0] atan_units(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			4'd0: v = 14'd8192;
			4'd1: v = 14'd4836;
			4'd2: v = 14'd2555;
			4'd3: v = 14'd1297;
			4'd4: v = 14'd651;
			4'd5: v = 14'd326;
			4'd6: v = 14'd163;
			4'd7: v = 14'd81;
			4'd8: v = 14'd41;
			4'd9: v = 14'd20;
			4'd10: v = 14'd10;
			4'd11: v = 14'd5;
			4'd12: v = 14'd3;
			4'd13: v = 14'd1;
			4'd14: v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sghs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface sghs_item_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [15:0]        cell_address;
	logic signed [7:0]  cell_value;
	logic [15:0]        range_mm;
	logic [11:0]        beam_index;
	logic               last_beam;

	modport source (output valid, command, cell_address, cell_value, range_mm, beam_index,
		last_beam, input ready);
	modport sink (input valid, command, cell_address, cell_value, range_mm, beam_index,
		last_beam, output ready);
endinterface

interface sghs_result_if;
	logic        valid;
	logic        ready;
	logic [12:0] hit_count;
	logic [15:0] score;

	modport source (output valid, hit_count, score, input ready);
	modport sink (input valid, hit_count, score, output ready);
endinterface
`default_nettype wire

/* rtl/core/sghs_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
module sghs_cordic (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [15:0]                           range_mm,
	input  wire  [sghs_pkg::ANG_W-1:0]            angle,
	output logic                                  done,
	output logic signed [sghs_pkg::CORDIC_W-1:0]  x,
	output logic signed [sghs_pkg::CORDIC_W-1:0]  y
);
	import sghs_pkg::*;

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [Z_W-1:0]      z_q;

	logic [ANG_W-1:0]           quarter;
	logic                       left_half;
	logic [ANG_W-1:0]           folded;
	logic signed [CORDIC_W-1:0] start_x;
	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;
	logic signed [Z_W-1:0]      dz;

	always_comb begin
		quarter   = angle + ANG_W'(16384);
		left_half = quarter[ANG_W-1];
		folded    = left_half ? angle + ANG_W'(32768) : angle;
		start_x   = CORDIC_W'({range_mm, 8'd0});
		if (left_half) begin
			start_x = -start_x;
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		dz = Z_W'(atan_units(step_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= start_x;
			y_q <= '0;
			z_q <= Z_W'($signed(folded));
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - dz;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + dz;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
endmodule
`default_nettype wire

/* rtl/core/sghs_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module sghs_divider (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  [sghs_pkg::DIVIDEND_W-1:0]     dividend,
	input  wire  [sghs_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                done,
	output logic [sghs_pkg::DIVIDEND_W-1:0]     quotient
);
	import sghs_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [DIVISOR_W-1:0]    div_q;
	logic [DIVISOR_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0]   quo_q;

	logic [DIVISOR_W:0]      trial;
	logic                    fits;
	logic [DIVISOR_W:0]      diff;

	// Restoring division, one quotient bit per cycle; the dividend shifts out
	// of the quotient register as quotient bits shift in.
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* rtl/core/scan_grid_hit_scoring.sv */
`timescale 1ns / 1ps
`default_nettype none
// A map-write item does not leave the idle state; the block is ready again at the next edge.
// A beam item holds the input off after its transfer while the block starts the rotation,
// runs the 16 CORDIC iterations, multiplies, adds the pose, starts the divider, runs the
// 33-bit division, then forms the address, reads the grid and compares; the division is the
// longest step. A last beam then passes to the emit state to load the result register and
// stays there while an earlier result still waits. Reset clears the control state and the hit
// counter and restores the register defaults; the grid contents are undefined until written.
module scan_grid_hit_scoring (
	input  wire                              clk,
	input  wire                              arst_n,
	sghs_item_if.sink                        items,
	sghs_result_if.source                    results,
	input  wire                              cfg_we,
	input  wire  [sghs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [sghs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sghs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ANGLE,
		S_CORDIC,
		S_MUL,
		S_POS,
		S_DSTART,
		S_DIV,
		S_ADDR,
		S_READ,
		S_SCORE,
		S_EMIT
	} state_t;

	state_t state_q;

	logic signed [POSE_W-1:0] pose_x_q;
	logic signed [POSE_W-1:0] pose_y_q;
	logic [ANG_W-1:0]         heading_q;
	logic [ANG_W-1:0]         step_q;
	logic [15:0]              cell_size_q;
	logic [8:0]               width_q;
	logic [8:0]               height_q;
	logic signed [7:0]        thr_q;

	logic [15:0]              range_q;
	logic [11:0]              idx_q;
	logic                     last_q;
	logic signed [PROD_W-1:0] prodx_q;
	logic signed [PROD_W-1:0] prody_q;
	logic signed [POS_W-1:0]  posx_q;
	logic signed [POS_W-1:0]  posy_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     inb_q;
	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic [CNT_W-1:0]         out_hits_q;
	logic [SCORE_W-1:0]       out_score_q;

	logic [7:0]               grid [GRID_CELLS];
	logic [7:0]               rd_q;

	logic                       item_fire;
	logic [ANG_W-1:0]           beam_angle;
	logic                       cordic_done;
	logic signed [CORDIC_W-1:0] cx;
	logic signed [CORDIC_W-1:0] cy;
	logic                       div_start;
	logic                       divx_done;
	logic                       divy_done;
	logic [DIVIDEND_W-1:0]      quo_x;
	logic [DIVIDEND_W-1:0]      quo_y;
	logic [DIVISOR_W-1:0]       cell_div;
	logic [LIM_W-1:0]           wlim;
	logic                       col_ok;
	logic                       row_ok;
	logic [ADDR_W:0]            lin_addr;
	logic signed [DELTA_W-1:0]  dx;
	logic signed [DELTA_W-1:0]  dy;
	logic signed [POSE_SH_W-1:0] pose_x_sh;
	logic signed [POSE_SH_W-1:0] pose_y_sh;
	logic                       hit;
	logic                       emit_fire;
	logic signed [GAIN_W-1:0]   inv_gain;

	always_comb begin
		item_fire  = items.valid && items.ready;
		beam_angle = heading_q + ANG_W'(idx_q * step_q);
		inv_gain   = GAIN_W'(INV_GAIN);
		dx         = prodx_q[PROD_W-1:FRAC_SHIFT];
		dy         = prody_q[PROD_W-1:FRAC_SHIFT];
		pose_x_sh  = {pose_x_q, 8'd0};
		pose_y_sh  = {pose_y_q, 8'd0};
		cell_div   = {(cell_size_q == 16'd0) ? 16'd1 : cell_size_q, 8'd0};
		wlim       = (32'(width_q) >= MAP_SIDE) ? LIM_W'(MAP_SIDE) : LIM_W'(width_q);
		col_ok     = !posx_q[POS_W-1] && (quo_x < DIVIDEND_W'(width_q))
			&& (quo_x < DIVIDEND_W'(MAP_SIDE));
		row_ok     = !posy_q[POS_W-1] && (quo_y < DIVIDEND_W'(height_q))
			&& (quo_y < DIVIDEND_W'(MAP_SIDE));
		lin_addr   = (ADDR_W+1)'(quo_y[CELL_W-1:0]) * (ADDR_W+1)'(wlim)
			+ (ADDR_W+1)'(quo_x[CELL_W-1:0]);
		hit        = inb_q && ($signed(rd_q) > thr_q);
		emit_fire  = (state_q == S_EMIT) && (!out_valid_q || results.ready);
		div_start  = state_q == S_DSTART;
	end

	assign items.ready       = state_q == S_IDLE;
	assign results.valid     = out_valid_q;
	assign results.hit_count = out_hits_q;
	assign results.score     = out_score_q;

	sghs_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_ANGLE),
		.range_mm (range_q),
		.angle    (beam_angle),
		.done     (cordic_done),
		.x        (cx),
		.y        (cy)
	);

	sghs_divider u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (posx_q[DIVIDEND_W-1:0]),
		.divisor  (cell_div),
		.done     (divx_done),
		.quotient (quo_x)
	);

	sghs_divider u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (posy_q[DIVIDEND_W-1:0]),
		.divisor  (cell_div),
		.done     (divy_done),
		.quotient (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			step_q      <= '0;
			cell_size_q <= 16'd50;
			width_q     <= 9'd256;
			height_q    <= 9'd256;
			thr_q       <= 8'sd50;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POSE_X:     pose_x_q    <= cfg_data;
				REG_POSE_Y:     pose_y_q    <= cfg_data;
				REG_HEADING:    heading_q   <= cfg_data[ANG_W-1:0];
				REG_ANGLE_STEP: step_q      <= cfg_data[ANG_W-1:0];
				REG_CELL_SIZE:  cell_size_q <= cfg_data[15:0];
				REG_MAP_WIDTH:  width_q     <= cfg_data[8:0];
				REG_MAP_HEIGHT: height_q    <= cfg_data[8:0];
				REG_THRESHOLD:  thr_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_fire && items.command == CMD_BEAM) begin
						state_q <= S_ANGLE;
					end
				end
				S_ANGLE: state_q <= S_CORDIC;
				S_CORDIC: begin
					if (cordic_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:    state_q <= S_POS;
				S_POS:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (divx_done && divy_done) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR:   state_q <= S_READ;
				S_READ:   state_q <= S_SCORE;
				S_SCORE: begin
					if (hit && count_q < CNT_W'(MAX_BEAMS)) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_fire) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			range_q <= items.range_mm;
			idx_q   <= items.beam_index;
			last_q  <= items.last_beam;
		end
		if (state_q == S_MUL) begin
			prodx_q <= PROD_W'(cx) * PROD_W'(inv_gain);
			prody_q <= PROD_W'(cy) * PROD_W'(inv_gain);
		end
		if (state_q == S_POS) begin
			posx_q <= POS_W'(pose_x_sh) + POS_W'(dx);
			posy_q <= POS_W'(pose_y_sh) + POS_W'(dy);
		end
		if (state_q == S_ADDR) begin
			addr_q <= lin_addr[ADDR_W-1:0];
			inb_q  <= col_ok && row_ok;
		end
		if (emit_fire) begin
			out_hits_q  <= count_q;
			out_score_q <= SCORE_W'((CNT_W+4)'(count_q) * (CNT_W+4)'(HIT_WEIGHT));
		end
	end

	// Grid store: one write port for map items, one registered read port.
	always_ff @(posedge clk) begin
		if (item_fire && items.command == CMD_WRITE
			&& 32'(items.cell_address) < GRID_CELLS) begin
			grid[ADDR_W'(items.cell_address)] <= items.cell_value;
		end
		rd_q <= grid[addr_q];
	end
endmodule
`default_nettype wire

/* rtl/core/sghs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module sghs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        in_command,
	input wire        out_valid,
	input wire        out_ready,
	input wire [12:0] out_hits,
	input wire [15:0] out_score
);
	import sghs_pkg::*;

	// A map write finishes in its own cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == CMD_WRITE |=> in_ready)
		else $error("map write did not complete in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_score == SCORE_W'(17'(out_hits) * 17'(HIT_WEIGHT)))
		else $error("score does not match hit count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_hits) <= MAX_BEAMS)
		else $error("hit count beyond saturation limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hits) && $stable(out_score))
		else $error("stalled result changed");
endmodule

bind scan_grid_hit_scoring sghs_checker u_sghs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.in_command (items.command),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_hits   (results.hit_count),
	.out_score  (results.score)
);
`default_nettype wire
